@@ rtl/core/qte_pkg.sv @@
// qte_pkg: types, constants and arithmetic helpers for quaternion_to_euler.
// No dependencies; used by every file in rtl/core.
package qte_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ANG_TAB_LEN  = 24;
  localparam int NSTEPS = (CORDIC_STEPS > ANG_TAB_LEN) ? ANG_TAB_LEN : CORDIC_STEPS;

  localparam int TERM_W = 34;   // matrix terms, Q.28 with headroom
  localparam int VEC_W  = 37;   // CORDIC x/y
  localparam int ANG_W  = 32;   // angle accumulator, 0.01 deg in Q.16
  localparam int SQ_STEPS = 29; // root bits of floor(sqrt(2^56 - s^2))
  localparam int RAD_W  = 2 * SQ_STEPS;
  localparam int REM_W  = SQ_STEPS + 2;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic signed [ANG_W-1:0]  ANG_90  = 32'sd589824000;
  localparam logic signed [TERM_W-1:0] ONE_Q28 = 34'sd268435456;
  localparam logic signed [15:0]       LIM_180 = 16'sd18000;
  localparam logic signed [15:0]       LIM_90  = 16'sd9000;

  typedef struct packed {
    logic signed [TERM_W-1:0] a12;
    logic signed [TERM_W-1:0] a22;
    logic signed [TERM_W-1:0] a31;
    logic signed [TERM_W-1:0] a32;
    logic signed [TERM_W-1:0] a33;
  } terms_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef struct packed {
    terms_t           t;
    logic             pos_sat;
    logic             neg_sat;
    logic [RAD_W-1:0] rad;
    logic [REM_W-1:0] rem;
    logic [SQ_STEPS-1:0] root;
  } sq_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [ANG_W-1:0] z;
    logic                    zero;
  } lane_t;

  typedef struct packed {
    lane_t yaw;
    lane_t pit;
    lane_t rol;
    logic  pos_sat;
    logic  neg_sat;
  } cd_t;

  function automatic logic signed [ANG_W-1:0] ang_tab(input int i);
    logic signed [ANG_W-1:0] r;
    unique case (i)
      0:  r = 32'sd294912000;
      1:  r = 32'sd174096719;
      2:  r = 32'sd91987925;
      3:  r = 32'sd46694507;
      4:  r = 32'sd23437865;
      5:  r = 32'sd11730358;
      6:  r = 32'sd5866610;
      7:  r = 32'sd2933484;
      8:  r = 32'sd1466764;
      9:  r = 32'sd733385;
      10: r = 32'sd366693;
      11: r = 32'sd183346;
      12: r = 32'sd91673;
      13: r = 32'sd45837;
      14: r = 32'sd22918;
      15: r = 32'sd11459;
      16: r = 32'sd5730;
      17: r = 32'sd2865;
      18: r = 32'sd1432;
      19: r = 32'sd716;
      20: r = 32'sd358;
      21: r = 32'sd179;
      22: r = 32'sd90;
      23: r = 32'sd45;
      default: r = '0;
    endcase
    return r;
  endfunction

  // quadrant fold: left half-plane turned by +/-90 degrees
  function automatic lane_t prerot(input logic signed [VEC_W-1:0] y,
                                   input logic signed [VEC_W-1:0] x);
    lane_t l;
    l.zero = (x == '0) && (y == '0);
    l.x = x;
    l.y = y;
    l.z = '0;
    if (x < 0) begin
      if (y >= 0) begin
        l.x = y;
        l.y = -x;
        l.z = ANG_90;
      end else begin
        l.x = -y;
        l.y = x;
        l.z = -ANG_90;
      end
    end
    return l;
  endfunction

  function automatic lane_t cstep(input lane_t l, input int i);
    lane_t r;
    logic signed [VEC_W-1:0] dx;
    logic signed [VEC_W-1:0] dy;
    dx = l.y >>> i;
    dy = l.x >>> i;
    r = l;
    if (l.y < 0) begin
      r.x = l.x - dx;
      r.y = l.y + dy;
      r.z = l.z - ang_tab(i);
    end else begin
      r.x = l.x + dx;
      r.y = l.y - dy;
      r.z = l.z + ang_tab(i);
    end
    return r;
  endfunction

  // round to nearest (ties up), then clamp to +/-lim; a zero vector gives 0
  function automatic logic signed [15:0] round_clamp(input lane_t l,
                                                     input logic signed [15:0] lim);
    logic signed [ANG_W-1:0] t;
    logic signed [15:0] a;
    t = l.z + 32'sd32768;
    a = 16'(t >>> 16);
    if (l.zero) a = '0;
    else if (a > lim) a = lim;
    else if (a < -lim) a = -lim;
    return a;
  endfunction

endpackage

@@ rtl/core/qte_front.sv @@
// qte_front: accepts quaternion words and forms the rotation-matrix terms.
// Depends on qte_pkg.
module qte_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic signed [15:0]    quat_w_i,
  input  logic signed [15:0]    quat_x_i,
  input  logic signed [15:0]    quat_y_i,
  input  logic signed [15:0]    quat_z_i,
  input  logic                  fifo_full_i,
  output logic                  push_o,
  output qte_pkg::terms_t       terms_o
);

  logic en;
  logic p_valid_q, t_valid_q;
  logic signed [31:0] ww_q, xx_q, yy_q, zz_q, xy_q, wz_q, wx_q, yz_q, xz_q, wy_q;
  qte_pkg::terms_t terms_d, terms_q;

  // whole front stalls only when a finished word cannot enter the queue
  assign en         = !(t_valid_q && fifo_full_i);
  assign in_ready_o = en;
  assign push_o     = t_valid_q && !fifo_full_i;
  assign terms_o    = terms_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      t_valid_q <= 1'b0;
    end else if (en) begin
      p_valid_q <= in_valid_i;
      t_valid_q <= p_valid_q;
    end
  end

  always_comb begin
    terms_d.a12 = (34'(xy_q) + 34'(wz_q)) <<< 1;
    terms_d.a22 = 34'(ww_q) + 34'(xx_q) - 34'(yy_q) - 34'(zz_q);
    terms_d.a31 = (34'(wx_q) + 34'(yz_q)) <<< 1;
    terms_d.a32 = (34'(xz_q) - 34'(wy_q)) <<< 1;
    terms_d.a33 = 34'(ww_q) - 34'(xx_q) - 34'(yy_q) + 34'(zz_q);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ww_q <= quat_w_i * quat_w_i;
      xx_q <= quat_x_i * quat_x_i;
      yy_q <= quat_y_i * quat_y_i;
      zz_q <= quat_z_i * quat_z_i;
      xy_q <= quat_x_i * quat_y_i;
      wz_q <= quat_w_i * quat_z_i;
      wx_q <= quat_w_i * quat_x_i;
      yz_q <= quat_y_i * quat_z_i;
      xz_q <= quat_x_i * quat_z_i;
      wy_q <= quat_w_i * quat_y_i;
      terms_q <= terms_d;
    end
  end

endmodule

@@ rtl/core/qte_fifo.sv @@
// qte_fifo: short register queue of matrix-term words between front and back.
// Depends on qte_pkg.
module qte_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  qte_pkg::terms_t      data_i,
  input  logic                 pop_i,
  output qte_pkg::terms_t      data_o,
  output qte_pkg::fifo_stat_t  stat_o
);

  qte_pkg::terms_t mem_q [qte_pkg::FIFO_DEPTH];
  logic [qte_pkg::FIFO_AW-1:0] wptr_q, rptr_q;
  logic [qte_pkg::FIFO_AW:0]   cnt_q;

  assign stat_o.full  = (cnt_q == (qte_pkg::FIFO_AW+1)'(qte_pkg::FIFO_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign data_o       = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + 1'b1;
      if (pop_i)  rptr_q <= rptr_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= data_i;
  end

endmodule

@@ rtl/core/qte_back.sv @@
// qte_back: pitch square root and three CORDIC vectoring lanes, one stage each.
// Depends on qte_pkg.
module qte_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  qte_pkg::terms_t     terms_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [15:0]  yaw_o,
  output logic signed [14:0]  pitch_o,
  output logic signed [15:0]  roll_o
);

  localparam int NS = qte_pkg::SQ_STEPS;
  localparam int NC = qte_pkg::NSTEPS;

  logic en;
  logic sq_v_q [NS+1];
  logic cd_v_q [NC+1];
  logic out_v_q;
  qte_pkg::sq_t sq_q [NS+1];
  qte_pkg::cd_t cd_q [NC+1];
  qte_pkg::sq_t sq0_d;
  qte_pkg::cd_t cd0_d;
  logic signed [qte_pkg::SQ_STEPS-1:0] s;
  logic signed [qte_pkg::RAD_W-1:0]    s2;
  logic signed [15:0] yaw_q, roll_q, pit16;
  logic signed [14:0] pit_q;

  assign en          = !out_v_q || out_ready_i;
  assign pop_o       = in_valid_i && en;
  assign out_valid_o = out_v_q;
  assign yaw_o       = yaw_q;
  assign pitch_o     = pit_q;
  assign roll_o      = roll_q;

  // stage 0: saturation test and s^2
  always_comb begin
    sq0_d.t       = terms_i;
    sq0_d.pos_sat = (terms_i.a32 >= qte_pkg::ONE_Q28);
    sq0_d.neg_sat = (terms_i.a32 <= -qte_pkg::ONE_Q28);
    s = (sq0_d.pos_sat || sq0_d.neg_sat) ? '0 : terms_i.a32[qte_pkg::SQ_STEPS-1:0];
    s2 = s * s;
    sq0_d.rad  = (qte_pkg::RAD_W'(1) << 56) - qte_pkg::RAD_W'(s2);
    sq0_d.rem  = '0;
    sq0_d.root = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= NS; k++) sq_v_q[k] <= 1'b0;
      for (int k = 0; k <= NC; k++) cd_v_q[k] <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      sq_v_q[0] <= in_valid_i;
      for (int k = 1; k <= NS; k++) sq_v_q[k] <= sq_v_q[k-1];
      cd_v_q[0] <= sq_v_q[NS];
      for (int k = 1; k <= NC; k++) cd_v_q[k] <= cd_v_q[k-1];
      out_v_q <= cd_v_q[NC];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) sq_q[0] <= sq0_d;
  end

  // one root bit per stage, restoring digit recurrence
  for (genvar k = 1; k <= NS; k++) begin : g_sqrt
    qte_pkg::sq_t d;
    logic [qte_pkg::REM_W+1:0] cur, trial;
    always_comb begin
      d     = sq_q[k-1];
      cur   = {sq_q[k-1].rem, sq_q[k-1].rad[2*(NS-k)+1 -: 2]};
      trial = (qte_pkg::REM_W+2)'({sq_q[k-1].root, 2'b01});
      if (cur >= trial) begin
        d.rem  = qte_pkg::REM_W'(cur - trial);
        d.root = {sq_q[k-1].root[NS-2:0], 1'b1};
      end else begin
        d.rem  = qte_pkg::REM_W'(cur);
        d.root = {sq_q[k-1].root[NS-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) sq_q[k] <= d;
    end
  end

  always_comb begin
    cd0_d.yaw = qte_pkg::prerot(qte_pkg::VEC_W'(sq_q[NS].t.a12),
                                qte_pkg::VEC_W'(sq_q[NS].t.a22));
    cd0_d.rol = qte_pkg::prerot(qte_pkg::VEC_W'(sq_q[NS].t.a31),
                                qte_pkg::VEC_W'(sq_q[NS].t.a33));
    cd0_d.pit = qte_pkg::prerot(qte_pkg::VEC_W'(sq_q[NS].t.a32),
                                qte_pkg::VEC_W'({1'b0, sq_q[NS].root}));
    cd0_d.pos_sat = sq_q[NS].pos_sat;
    cd0_d.neg_sat = sq_q[NS].neg_sat;
  end

  always_ff @(posedge clk_i) begin
    if (en) cd_q[0] <= cd0_d;
  end

  for (genvar j = 1; j <= NC; j++) begin : g_cordic
    qte_pkg::cd_t d;
    always_comb begin
      d     = cd_q[j-1];
      d.yaw = qte_pkg::cstep(cd_q[j-1].yaw, j-1);
      d.pit = qte_pkg::cstep(cd_q[j-1].pit, j-1);
      d.rol = qte_pkg::cstep(cd_q[j-1].rol, j-1);
    end
    always_ff @(posedge clk_i) begin
      if (en) cd_q[j] <= d;
    end
  end

  assign pit16 = cd_q[NC].pos_sat ? qte_pkg::LIM_90 :
                 cd_q[NC].neg_sat ? -qte_pkg::LIM_90 :
                 qte_pkg::round_clamp(cd_q[NC].pit, qte_pkg::LIM_90);

  always_ff @(posedge clk_i) begin
    if (en) begin
      yaw_q  <= qte_pkg::round_clamp(cd_q[NC].yaw, qte_pkg::LIM_180);
      roll_q <= qte_pkg::round_clamp(cd_q[NC].rol, qte_pkg::LIM_180);
      pit_q  <= pit16[14:0];
    end
  end

endmodule

@@ rtl/core/quaternion_to_euler.sv @@
// quaternion_to_euler: top level, attitude quaternion to ZYX Euler angles.
// Depends on qte_pkg, qte_front, qte_fifo and qte_back.
//
// Use:
//   s_axis carries one quaternion word (w, x, y, z, signed Q1.14). m_axis
//   returns one word per input: yaw, pitch and roll in signed hundredths
//   of a degree, rounded to nearest; pitch saturates at +/-90 degrees.
//   Throughput: one word per cycle, sustained, while m_axis_tready_i is high.
//   Pipeline, from input acceptance to output valid: two multiply/add stages
//   in the front, one queue slot, one squaring stage, 29 square-root stages
//   (one root bit each), one quadrant fold, CORDIC_STEPS micro-rotation
//   stages and the output register.
//   Front and back are parted by a four-word queue: a stalled receiver
//   freezes the back pipeline; the front keeps taking words until the queue
//   fills, then s_axis_tready_o drops.
//   Reset (rst_ni low, asynchronous) empties every valid bit and the queue;
//   there is no other state and nothing to configure.
module quaternion_to_euler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [15:0] quat_w, [31:16] quat_x, [47:32] quat_y, [63:48] quat_z
  input  logic [63:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [15:0] yaw_angle, [30:16] pitch_angle, [46:31] roll_angle, [47] zero
  output logic [47:0] m_axis_tdata_o
);

  logic                push;
  logic                pop;
  qte_pkg::terms_t     front_terms;
  qte_pkg::terms_t     fifo_terms;
  qte_pkg::fifo_stat_t fifo_stat;
  logic signed [15:0]  yaw_angle;
  logic signed [14:0]  pitch_angle;
  logic signed [15:0]  roll_angle;

  // front: products and matrix terms
  qte_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .quat_w_i    (s_axis_tdata_i[15:0]),
    .quat_x_i    (s_axis_tdata_i[31:16]),
    .quat_y_i    (s_axis_tdata_i[47:32]),
    .quat_z_i    (s_axis_tdata_i[63:48]),
    .fifo_full_i (fifo_stat.full),
    .push_o      (push),
    .terms_o     (front_terms)
  );

  qte_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (front_terms),
    .pop_i  (pop),
    .data_o (fifo_terms),
    .stat_o (fifo_stat)
  );

  // back: sqrt for pitch, three CORDIC lanes, output register
  qte_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (!fifo_stat.empty),
    .terms_i     (fifo_terms),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .yaw_o       (yaw_angle),
    .pitch_o     (pitch_angle),
    .roll_o      (roll_angle)
  );

  assign m_axis_tdata_o = {1'b0, roll_angle, pitch_angle, yaw_angle};

`ifndef SYNTHESIS
  a_fifo_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fifo_stat.full && fifo_stat.empty))
    else $error("queue full and empty together");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !fifo_stat.empty)
    else $error("pop from empty queue");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> fifo_stat.full)
    else $error("input stalled with room in queue");

  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ($signed(pitch_angle) <= 15'sd9000 &&
                         $signed(pitch_angle) >= -15'sd9000))
    else $error("pitch out of range");

  a_yaw_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (yaw_angle <= 16'sd18000 && yaw_angle >= -16'sd18000))
    else $error("yaw out of range");
`endif

endmodule

@@ sim/tb_quaternion_to_euler.sv @@
// tb_quaternion_to_euler: self-checking bench for the quaternion to Euler block.
// Needs qte_pkg and quaternion_to_euler; predicts yaw, pitch and roll per word
// with its own fixed-point CORDIC and compares every output word in order.
module tb_quaternion_to_euler;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint QUARTER_TURN = 64'sd589824000; // 90 deg, 0.01 deg in Q.16
  localparam longint UNIT_Q28     = 64'sd268435456;
  localparam int     IDLE_LIMIT   = 3000;           // cycles with no word moved
  localparam int     HOLD_CYCLES  = 400;            // long receiver hold-off

  // atan(2^-i) in hundredths of a degree, Q.16
  localparam longint ATAN_LUT [24] = '{
    294912000, 174096719, 91987925, 46694507, 23437865, 11730358, 5866610,
    2933484, 1466764, 733385, 366693, 183346, 91673, 45837, 22918, 11459,
    5730, 2865, 1432, 716, 358, 179, 90, 45};

  typedef struct {
    logic signed [15:0] yaw;
    logic signed [14:0] pitch;
    logic signed [15:0] roll;
  } angles_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_valid;
  logic        s_ready;
  logic [63:0] s_data;
  logic        m_valid;
  logic        m_ready;
  logic [47:0] m_data;

  // values seen just before the coming rising edge
  logic        s_ready_q;
  logic        m_valid_q;
  logic [47:0] m_data_q;

  angles_t angles_due[$];
  int      errors;
  int      idle_cycles;
  bit      tx_idle_en;
  bit      rx_idle_en;
  bit      hold_req;

  quaternion_to_euler dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    // [15:0] quat_w, [31:16] quat_x, [47:32] quat_y, [63:48] quat_z
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    // [15:0] yaw_angle, [30:16] pitch_angle, [46:31] roll_angle, [47] zero
    .m_axis_tdata_o  (m_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    s_ready_q = s_ready;
    m_valid_q = m_valid;
    m_data_q  = m_data;
  end

  // ---------------------------------------------------------------- predictor
  function automatic longint floor_sqrt(input longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   -= res + bitv;
        res  = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  // vectoring CORDIC: angle of (x, y) in 0.01 deg, rounded, clamped to lim
  function automatic longint vector_angle(input longint y, input longint x,
                                          input longint lim);
    longint acc;
    longint t;
    longint dx;
    longint dy;
    longint a;
    int     n;
    if (x == 0 && y == 0) return 0;
    acc = 0;
    n   = (qte_pkg::CORDIC_STEPS > qte_pkg::ANG_TAB_LEN) ? qte_pkg::ANG_TAB_LEN
                                                          : qte_pkg::CORDIC_STEPS;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; acc = QUARTER_TURN;
      end else begin
        x = -y; y = t; acc = -QUARTER_TURN;
      end
    end
    for (int i = 0; i < n; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y < 0) begin
        x -= dx; y += dy; acc -= ATAN_LUT[i];
      end else begin
        x += dx; y -= dy; acc += ATAN_LUT[i];
      end
    end
    a = (acc + 32768) >>> 16;
    if (a > lim) a = lim;
    if (a < -lim) a = -lim;
    return a;
  endfunction

  function automatic angles_t euler_of(input logic signed [15:0] qw,
                                       input logic signed [15:0] qx,
                                       input logic signed [15:0] qy,
                                       input logic signed [15:0] qz);
    longint  w, x, y, z;
    longint  a12, a22, a31, a32, a33;
    longint  c;
    angles_t r;
    w = qw; x = qx; y = qy; z = qz;
    a12 = 2 * (x * y + w * z);
    a22 = w * w + x * x - y * y - z * z;
    a31 = 2 * (w * x + y * z);
    a32 = 2 * (x * z - w * y);
    a33 = w * w - x * x - y * y + z * z;
    r.yaw  = 16'(vector_angle(a12, a22, 18000));
    r.roll = 16'(vector_angle(a31, a33, 18000));
    if (a32 >= UNIT_Q28) r.pitch = 15'sd9000;
    else if (a32 <= -UNIT_Q28) r.pitch = -15'sd9000;
    else begin
      c = floor_sqrt((64'd1 << 56) - longint'(a32 * a32));
      r.pitch = 15'(vector_angle(a32, c, 9000));
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- helpers
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string what, input int want, input int got);
    $display("mismatch %s: expected %0d, got %0d (t=%0t)", what, want, got, $realtime);
    errors++;
  endtask

  // offer one word; valid stays high into the next call when no gap is drawn
  task automatic send_quat(input logic [15:0] w, input logic [15:0] x,
                           input logic [15:0] y, input logic [15:0] z);
    int g;
    g = tx_idle_en ? gap_len() : 0;
    if (g > 0) begin
      s_valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {z, y, x, w};
    do @(posedge clk_i); while (!s_ready_q);
    angles_due.push_back(euler_of(w, x, y, z));
  endtask

  // input goes idle, then wait for every outstanding word
  task automatic wait_drained();
    s_valid <= 1'b0;
    while (angles_due.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------- receiver
  initial begin
    int g;
    m_ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        m_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
        m_ready <= 1'b1;
        @(posedge clk_i);
      end else begin
        g = rx_idle_en ? gap_len() : 0;
        if (g > 0) begin
          m_ready <= 1'b0;
          repeat (g) @(posedge clk_i);
        end
        m_ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // output checker: oldest expectation against each accepted word
  always @(posedge clk_i) begin
    angles_t want;
    angles_t got;
    if (rst_ni && m_valid_q && m_ready) begin
      got.yaw   = m_data_q[15:0];
      got.pitch = m_data_q[30:16];
      got.roll  = m_data_q[46:31];
      if (angles_due.size() == 0) begin
        $display("unexpected output word %h (t=%0t)", m_data_q, $realtime);
        errors++;
      end else begin
        want = angles_due.pop_front();
        if (got.yaw !== want.yaw) report_mismatch("yaw", want.yaw, got.yaw);
        if (got.pitch !== want.pitch) report_mismatch("pitch", want.pitch, got.pitch);
        if (got.roll !== want.roll) report_mismatch("roll", want.roll, got.roll);
      end
    end
  end

  // watchdog: nothing moving on either side for too long ends the run
  always @(posedge clk_i) begin
    if ((s_valid && s_ready_q) || (m_valid_q && m_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
      $display("tb_quaternion_to_euler NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests
  task automatic test_directed();
    send_quat(16'sd16384, 0, 0, 0);                 // identity
    send_quat(16'sd0, 0, 0, 16'sd16384);            // yaw 180: zero y, negative x
    send_quat(16'sd0, 16'sd16384, 0, 0);            // roll 180
    send_quat(16'sd11585, 0, 0, 16'sd11585);        // yaw +90
    send_quat(16'sd11585, 0, 0, -16'sd11585);       // yaw -90
    send_quat(16'sd11585, 16'sd11585, 0, 0);        // roll +90
    send_quat(16'sd11585, 0, 16'sd11585, 0);        // pitch just short of -90
    send_quat(16'sd11586, 0, 16'sd11586, 0);        // pitch saturates negative
    send_quat(16'sd11586, 0, -16'sd11586, 0);       // pitch saturates positive
    send_quat(16'sd16384, 0, 16'sd16384, 0);        // non-unit, a32 = -2.0
    send_quat(0, 0, 0, 0);                          // all operands zero
    send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_quat(16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
    send_quat(16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
    send_quat(16'h8000, 0, 0, 0);
    send_quat(0, 16'h8000, 0, 0);
    send_quat(0, 0, 16'h8000, 0);
    send_quat(0, 0, 0, 16'h8000);
    send_quat(16'sd1, 16'sd1, 16'sd1, 16'sd1);      // tiny vectors
    send_quat(-16'sd1, 0, 0, 0);
    send_quat(16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192);
    send_quat(16'sd8192, -16'sd8192, 16'sd8192, -16'sd8192);
    wait_drained();   // sender pauses until every output word is back
  endtask

  // random attitudes close to unit length, the block's normal diet
  task automatic test_unit_quats(input int count);
    real c[4];
    real nrm;
    logic [15:0] q[4];
    for (int k = 0; k < count; k++) begin
      nrm = 0.0;
      for (int j = 0; j < 4; j++) begin
        c[j] = real'(int'($urandom_range(0, 65535)) - 32768);
        if ($urandom_range(0, 7) == 0) c[j] = 0.0;   // axis-aligned cases
        nrm += c[j] * c[j];
      end
      if (nrm == 0.0) begin
        c[0] = 1.0; nrm = 1.0;
      end
      nrm = $sqrt(nrm);
      for (int j = 0; j < 4; j++)
        q[j] = 16'(int'($floor(c[j] / nrm * 16384.0 + 0.5))
                   + int'($urandom_range(0, 6)) - 3);
      send_quat(q[0], q[1], q[2], q[3]);
      if (k == count / 2) begin
        tx_idle_en = 1'b0;   // a stretch with no idling on either side
        rx_idle_en = 1'b0;
      end
      if (k == count / 2 + 150) begin
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
      end
    end
  endtask

  // raw words: every bit of every field, unnormalised terms
  task automatic test_raw_words(input int count);
    for (int k = 0; k < count; k++)
      send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // receiver holds off while words keep coming: queue fills, input stalls
  task automatic test_backpressure();
    tx_idle_en = 1'b0;
    hold_req   = 1'b1;
    test_unit_quats(70);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    wait_drained();
  endtask

  initial begin
    errors      = 0;
    idle_cycles = 0;
    tx_idle_en  = 1'b1;
    rx_idle_en  = 1'b1;
    hold_req    = 1'b0;
    s_valid     <= 1'b0;
    s_data      <= '0;
    rst_ni      <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_unit_quats(820);
    test_backpressure();
    test_raw_words(240);

    s_valid <= 1'b0;
    wait_drained();
    repeat (100) @(posedge clk_i);
    if (errors == 0) $display("tb_quaternion_to_euler OK");
    else $display("tb_quaternion_to_euler NOT OK");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/qte_pkg.sv
rtl/core/qte_front.sv
rtl/core/qte_fifo.sv
rtl/core/qte_back.sv
rtl/core/quaternion_to_euler.sv
sim/tb_quaternion_to_euler.sv
